@@ rtl/life_automaton_grid_step_unit_assert.svh @@
// Assertion macros shared by the grid step unit.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef LIFE_AUTOMATON_GRID_STEP_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_STEP_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define LGS_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("grid step unit: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define LGS_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("grid step unit: next-cycle check failed");

`endif

@@ rtl/lgs_pkg.sv @@
package lgs_pkg;

    localparam int CMD_W      = 2;
    localparam int ROW_IDX_W  = 4;
    localparam int ROW_BITS_W = 16;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 24;
    localparam int NBR_CNT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_ROWS = 1'd0,
        REG_ACTIVE_COLS = 1'd1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0]     ACTIVE_RESET  = 5'd10;
    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

@@ rtl/lgs_row_lane.sv @@
module lgs_row_lane #(
    parameter int COLS = 16
) (
    input  logic [COLS-1:0] up,
    input  logic [COLS-1:0] mid,
    input  logic [COLS-1:0] dn,
    input  logic            row_en,
    input  logic [COLS-1:0] col_mask,
    output logic [COLS-1:0] nxt
);
    import lgs_pkg::*;

    logic [COLS+1:0] up_x;
    logic [COLS+1:0] mid_x;
    logic [COLS+1:0] dn_x;

    // Pad a dead column on each side so the edge cells see no wraparound.
    assign up_x  = {1'b0, up, 1'b0};
    assign mid_x = {1'b0, mid, 1'b0};
    assign dn_x  = {1'b0, dn, 1'b0};

    always_comb
    begin
        logic [NBR_CNT_W-1:0] cnt;
        for (int c = 0; c < COLS; c++)
        begin
            cnt = NBR_CNT_W'(up_x[c]) + NBR_CNT_W'(up_x[c+1]) + NBR_CNT_W'(up_x[c+2])
                + NBR_CNT_W'(mid_x[c]) + NBR_CNT_W'(mid_x[c+2])
                + NBR_CNT_W'(dn_x[c]) + NBR_CNT_W'(dn_x[c+1]) + NBR_CNT_W'(dn_x[c+2]);
            nxt[c] = ((cnt == BIRTH_COUNT) || (mid[c] && (cnt == SURVIVE_COUNT)))
                     && col_mask[c] && row_en;
        end
    end

endmodule

@@ rtl/lgs_read_merge.sv @@
module lgs_read_merge #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic [ROWS-1:0][COLS-1:0]     grid,
    input  logic [ROWS-1:0]               row_act,
    input  logic [lgs_pkg::ROW_IDX_W-1:0] row_index,
    output logic [lgs_pkg::ROW_BITS_W-1:0] row_word
);
    import lgs_pkg::*;

    logic [COLS-1:0] sel;

    // One-hot row select folded into an OR tree; an inactive or absent row reads as zero.
    always_comb
    begin
        sel = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if ((r == int'(row_index)) && row_act[r])
            begin
                sel = sel | grid[r];
            end
        end
    end

    generate
        if (COLS >= ROW_BITS_W)
        begin : g_trunc
            assign row_word = sel[ROW_BITS_W-1:0];
        end
        else
        begin : g_ext
            assign row_word = {{(ROW_BITS_W-COLS){1'b0}}, sel};
        end
    endgenerate

endmodule

@@ rtl/life_automaton_grid_step_unit.sv @@
// A result beat appears on the master side in the cycle after its input beat is taken.
// One command per cycle while the master side keeps up and no configuration beat is waiting.
// A step updates every cell at once, as the row lanes evaluate all rows side by side.
// Reset (rst_n low, asynchronous) kills every cell and sets both active counts to ten.
`include "life_automaton_grid_step_unit_assert.svh"

module life_automaton_grid_step_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0: row_index [3:0], row_bits [19:4], zero fill [23:20].
    input  logic [lgs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0: cmd [1:0].
    input  logic [lgs_pkg::CMD_W-1:0]       s_tuser,
    // Result beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0: row_data [15:0].
    output logic [lgs_pkg::ROW_BITS_W-1:0]  m_tdata,
    // Configuration writes: index 0 is active_rows, index 1 is active_cols.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]       cfg_data
);
    import lgs_pkg::*;

    // The grid lives in flip-flops, one per cell, so that every row lane sees its
    // neighbors directly. Cells outside the active area are kept at zero at all times:
    // every update of the grid passes through the active-area mask.
    logic [MAX_ROWS-1:0][MAX_COLS-1:0] grid_reg;
    logic [MAX_ROWS-1:0][MAX_COLS-1:0] grid_next;
    logic [MAX_ROWS-1:0][MAX_COLS-1:0] lane_next;

    logic [CFG_W-1:0] active_rows_reg;
    logic [CFG_W-1:0] active_rows_next;
    logic [CFG_W-1:0] active_cols_reg;
    logic [CFG_W-1:0] active_cols_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROW_BITS_W-1:0] out_data_reg;
    logic [ROW_BITS_W-1:0] out_data_next;

    logic                  s_accept;
    logic                  cfg_accept;
    cmd_t                  cmd;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [MAX_COLS-1:0]   row_bits_fit;
    logic [ROW_BITS_W-1:0] read_word;

    logic [MAX_ROWS-1:0]   row_act;
    logic [MAX_ROWS-1:0]   row_act_new;
    logic [MAX_COLS-1:0]   col_mask;
    logic [MAX_COLS-1:0]   col_mask_new;
    logic                  outside_clear;

    assign cmd       = cmd_t'(s_tuser);
    assign row_index = s_tdata[ROW_IDX_W-1:0];
    assign row_bits  = s_tdata[ROW_IDX_W +: ROW_BITS_W];

    // A configuration beat is always taken at once. Commands hold off for that cycle so
    // the area change and a grid update never collide. The output register frees up as
    // soon as its beat is taken, so a stall on the master side only stalls when full.
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = (!out_valid_reg || m_tready) && !cfg_valid;
    assign s_accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    generate
        if (MAX_COLS > ROW_BITS_W)
        begin : g_wr_ext
            assign row_bits_fit = {{(MAX_COLS-ROW_BITS_W){1'b0}}, row_bits};
        end
        else
        begin : g_wr_trunc
            assign row_bits_fit = row_bits[MAX_COLS-1:0];
        end
    endgenerate

    // Register writes. An out-of-range index never arises with a one-bit index.
    always_comb
    begin
        active_rows_next = active_rows_reg;
        active_cols_next = active_cols_reg;
        if (cfg_accept)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_ROWS: active_rows_next = cfg_data;
                REG_ACTIVE_COLS: active_cols_next = cfg_data;
                default:         active_rows_next = active_rows_reg;
            endcase
        end
    end

    // Active-area masks. A row or column counts as active when its number is below the
    // register value; values above the grid size simply cover the whole grid. The masks
    // from the incoming values clear whatever falls outside a shrunken area.
    always_comb
    begin
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_act[r]     = r < int'(active_rows_reg);
            row_act_new[r] = r < int'(active_rows_next);
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c]     = c < int'(active_cols_reg);
            col_mask_new[c] = c < int'(active_cols_next);
        end
    end

    // One lane per row computes that row's next generation from its two neighbors.
    genvar gr;
    generate
        for (gr = 0; gr < MAX_ROWS; gr++)
        begin : g_lane
            logic [MAX_COLS-1:0] up_row;
            logic [MAX_COLS-1:0] dn_row;
            if (gr > 0)
            begin : g_up
                assign up_row = grid_reg[gr-1];
            end
            else
            begin : g_up_edge
                assign up_row = '0;
            end
            if (gr < MAX_ROWS - 1)
            begin : g_dn
                assign dn_row = grid_reg[gr+1];
            end
            else
            begin : g_dn_edge
                assign dn_row = '0;
            end
            lgs_row_lane #(
                .COLS(MAX_COLS)
            ) u_lane (
                .up      (up_row),
                .mid     (grid_reg[gr]),
                .dn      (dn_row),
                .row_en  (row_act[gr]),
                .col_mask(col_mask),
                .nxt     (lane_next[gr])
            );
        end
    endgenerate

    // Merging stage: picks the addressed row for a read.
    lgs_read_merge #(
        .ROWS(MAX_ROWS),
        .COLS(MAX_COLS)
    ) u_merge (
        .grid     (grid_reg),
        .row_act  (row_act),
        .row_index(row_index),
        .row_word (read_word)
    );

    // Grid update and result formation.
    always_comb
    begin
        grid_next      = grid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (s_accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            unique case (cmd)
                CMD_WRITE:
                begin
                    for (int r = 0; r < MAX_ROWS; r++)
                    begin
                        if (r == int'(row_index))
                        begin
                            grid_next[r] = row_bits_fit;
                        end
                    end
                end
                CMD_STEP:  grid_next     = lane_next;
                CMD_READ:  out_data_next = read_word;
                CMD_NOP:   out_data_next = '0;
                default:   out_data_next = '0;
            endcase
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            grid_next[r] = grid_next[r] & col_mask_new & {MAX_COLS{row_act_new[r]}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg        <= '0;
            active_rows_reg <= ACTIVE_RESET;
            active_cols_reg <= ACTIVE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            grid_reg        <= grid_next;
            active_rows_reg <= active_rows_next;
            active_cols_reg <= active_cols_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // True while no live cell sits outside the active area.
    always_comb
    begin
        outside_clear = 1'b1;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if ((grid_reg[r] & ~(col_mask & {MAX_COLS{row_act[r]}})) != '0)
            begin
                outside_clear = 1'b0;
            end
        end
    end

    `LGS_ASSERT_SAME(a_outside_dead, clk, rst_n, 1'b1, outside_clear)
    `LGS_ASSERT_NEXT(a_accept_gives_beat, clk, rst_n, s_accept, m_tvalid)
    `LGS_ASSERT_NEXT(a_nonread_zero, clk, rst_n, s_accept && (cmd != CMD_READ), m_tdata == '0)
    `LGS_ASSERT_SAME(a_cfg_blocks_cmd, clk, rst_n, cfg_valid, !s_tready)

endmodule

@@ bench/tb_life_automaton_grid_step_unit.sv @@
module tb_life_automaton_grid_step_unit;

    import lgs_pkg::*;

    // The grid size used for this run matches the default build of the block.
    localparam int GRID_ROWS     = 16;
    localparam int GRID_COLS     = 16;
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    // Chance in a hundred that a side idles in a given cycle.
    localparam int IDLE_PCT      = 33;
    // The block answers in the cycle after it takes a command; the spare cycles below cover that.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 12;
    localparam int PHASE_BEATS   = 86;
    // Roughly 1250 commands are sent with modest stalls.
    // The limit below is in simulation time units and leaves ample room for them.
    localparam int TIMEOUT_UNITS = 400000;
    // Rule B3/S23: a dead cell with three neighbors is born,
    // and a live cell with two or three neighbors survives.
    localparam int BIRTH_NBRS    = 3;
    localparam int KEEP_NBRS     = 2;

    // What the driver does next: send a command beat, write a register,
    // or hold off until every outstanding result has come back.
    typedef enum logic [1:0] {
        PLAN_BEAT,
        PLAN_REG,
        PLAN_PAUSE
    } plan_kind_t;

    typedef struct {
        plan_kind_t      kind;
        cmd_t            op;
        logic [3:0]      row;
        logic [15:0]     bits;
        cfg_reg_t        sel;
        logic [CFG_W-1:0] value;
    } plan_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata fields from bit 0: row_index [3:0], row_bits [19:4], zero fill [23:20].
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // s_tuser fields from bit 0: cmd [1:0].
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata fields from bit 0: row_data [15:0].
    logic [ROW_BITS_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Mirror of the block: the cell grid and the two area registers.
    logic [GRID_COLS-1:0]   life_cells [GRID_ROWS];
    logic [CFG_W-1:0]       area_rows;
    logic [CFG_W-1:0]       area_cols;

    // Row data that the block still owes, oldest first.
    logic [15:0]            row_data_expected [$];
    logic [15:0]            expected_row;
    plan_entry_t            beat_plan [$];
    plan_entry_t            head;

    bit                     cmd_taken = 1'b0;
    bit                     cfg_taken = 1'b0;
    bit                     cmd_busy = 1'b0;
    bit                     cfg_busy = 1'b0;
    bit                     quiet = 1'b0;
    int                     settle_left = 0;
    int                     beats_sent = 0;
    int                     failures = 0;
    int                     results_checked = 0;
    int                     live_reads = 0;
    int                     reg_writes = 0;
    int                     beats_by_cmd [4] = '{0, 0, 0, 0};

    life_automaton_grid_step_unit #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Counts above the grid size saturate at the grid size.
    function automatic int live_row_limit();
        return (area_rows > GRID_ROWS) ? GRID_ROWS : int'(area_rows);
    endfunction

    function automatic int live_col_limit();
        return (area_cols > GRID_COLS) ? GRID_COLS : int'(area_cols);
    endfunction

    function automatic logic [GRID_COLS-1:0] live_col_mask();
        logic [GRID_COLS-1:0] mask;
        mask = '0;
        for (int c = 0; c < live_col_limit(); c++)
            mask[c] = 1'b1;
        return mask;
    endfunction

    // Every cell outside the active area is killed, so it stays dead
    // even if the area grows again later.
    function automatic void clear_dead_zone();
        logic [GRID_COLS-1:0] mask;
        int                   nr;
        mask = live_col_mask();
        nr   = live_row_limit();
        for (int r = 0; r < GRID_ROWS; r++)
            life_cells[r] = (r < nr) ? (life_cells[r] & mask) : '0;
    endfunction

    function automatic void set_area_register(cfg_reg_t sel, logic [CFG_W-1:0] value);
        case (sel)
            REG_ACTIVE_ROWS: area_rows = value;
            REG_ACTIVE_COLS: area_cols = value;
            default: ;
        endcase
        clear_dead_zone();
    endfunction

    // One generation: all cells update at once from the old grid.
    // Neighbors beyond the active area count as dead and nothing wraps.
    function automatic void advance_generation();
        logic [GRID_COLS-1:0] next_cells [GRID_ROWS];
        int                   nr;
        int                   nc;
        int                   nbrs;
        int                   rr;
        int                   cc;
        nr = live_row_limit();
        nc = live_col_limit();
        for (int r = 0; r < GRID_ROWS; r++)
            next_cells[r] = '0;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                            nbrs += life_cells[rr][cc];
                    end
                end
                if (nbrs == BIRTH_NBRS || (life_cells[r][c] && nbrs == KEEP_NBRS))
                    next_cells[r][c] = 1'b1;
            end
        end
        for (int r = 0; r < GRID_ROWS; r++)
            life_cells[r] = next_cells[r];
    endfunction

    // Applies one command to the mirror and returns the row data it should produce.
    function automatic logic [15:0] apply_grid_command(cmd_t op, logic [3:0] row,
                                                       logic [15:0] bits);
        logic [15:0] row_data;
        row_data = '0;
        case (op)
            CMD_WRITE:
                if (row < live_row_limit())
                    life_cells[row] = bits & live_col_mask();
            CMD_STEP:
                advance_generation();
            CMD_READ:
                if (row < live_row_limit())
                    row_data = life_cells[row] & live_col_mask();
            default: ;
        endcase
        return row_data;
    endfunction

    task automatic plan_command(cmd_t op, int row, logic [15:0] bits);
        plan_entry_t e;
        e = '{PLAN_BEAT, op, 4'(row), bits, REG_ACTIVE_ROWS, '0};
        beat_plan.push_back(e);
    endtask

    task automatic plan_pause();
        plan_entry_t e;
        e = '{PLAN_PAUSE, CMD_NOP, 4'd0, 16'd0, REG_ACTIVE_ROWS, '0};
        beat_plan.push_back(e);
    endtask

    // Registers are only written once the block has drained.
    task automatic plan_area(int rows, int cols);
        plan_entry_t e;
        plan_pause();
        e = '{PLAN_REG, CMD_NOP, 4'd0, 16'd0, REG_ACTIVE_ROWS, CFG_W'(rows)};
        beat_plan.push_back(e);
        e = '{PLAN_REG, CMD_NOP, 4'd0, 16'd0, REG_ACTIVE_COLS, CFG_W'(cols)};
        beat_plan.push_back(e);
    endtask

    // Row patterns from sparse to dense, so that the grid neither dies out
    // at once nor stays frozen solid.
    function automatic logic [15:0] pattern_bits(int density);
        case (density)
            0: return 16'($urandom & $urandom & $urandom);
            1: return 16'($urandom & $urandom);
            2: return 16'($urandom);
            default: return 16'($urandom | $urandom);
        endcase
    endfunction

    // Stimulus: a short directed part, then phases of random commands,
    // each phase under its own active area.
    initial
    begin
        int rows_sel;
        int cols_sel;
        int density;
        int pick;

        for (int r = 0; r < GRID_ROWS; r++)
            life_cells[r] = '0;
        area_rows = ACTIVE_RESET;
        area_cols = ACTIVE_RESET;

        // Reset area of ten by ten: an empty read, a full write that loses the
        // bits beyond the active columns, a write and a read outside the active
        // rows, a no-op, and a blinker on the left edge that must not wrap.
        plan_command(CMD_READ, 0, 16'h0000);
        plan_command(CMD_WRITE, 0, 16'hFFFF);
        plan_command(CMD_READ, 0, 16'h0000);
        plan_command(CMD_WRITE, 15, 16'hFFFF);
        plan_command(CMD_READ, 15, 16'hFFFF);
        plan_command(CMD_NOP, 3, 16'hFFFF);
        plan_command(CMD_WRITE, 4, 16'h0007);
        plan_command(CMD_STEP, 0, 16'h0000);
        plan_command(CMD_READ, 0, 16'h0000);
        plan_command(CMD_READ, 3, 16'h0000);
        plan_command(CMD_READ, 4, 16'h0000);

        // The full grid, with its last row and last column in play.
        plan_area(GRID_ROWS, GRID_COLS);
        plan_command(CMD_WRITE, 15, 16'hFFFF);
        plan_command(CMD_STEP, 0, 16'h0000);
        plan_command(CMD_READ, 15, 16'h0000);

        // Counts beyond the grid act as the grid size.
        plan_area(31, 31);
        plan_command(CMD_READ, 14, 16'h0000);

        // An empty area: everything is dead and stays so.
        plan_area(0, 0);
        plan_command(CMD_WRITE, 0, 16'hFFFF);
        plan_command(CMD_READ, 0, 16'h0000);
        plan_command(CMD_STEP, 0, 16'h0000);
        plan_area(GRID_ROWS, GRID_COLS);
        plan_command(CMD_READ, 14, 16'h0000);

        // Shrinking the area kills row five for good.
        plan_command(CMD_WRITE, 5, 16'hAAAA);
        plan_area(3, 3);
        plan_area(GRID_ROWS, GRID_COLS);
        plan_command(CMD_READ, 5, 16'h0000);

        // Random phases: fill every row, then let the pattern evolve
        // while it is written, read and stepped.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin rows_sel = 1;  cols_sel = 1;  end
                1: begin rows_sel = 16; cols_sel = 16; end
                2: begin rows_sel = 2;  cols_sel = 16; end
                3: begin rows_sel = 16; cols_sel = 2;  end
                4: begin rows_sel = 31; cols_sel = 17; end
                5: begin rows_sel = 7;  cols_sel = 12; end
                6: begin rows_sel = 16; cols_sel = 16; end
                default:
                begin
                    rows_sel = $urandom_range(1, 20);
                    cols_sel = $urandom_range(1, 20);
                end
            endcase
            plan_area(rows_sel, cols_sel);
            density = $urandom_range(3);
            for (int r = 0; r < GRID_ROWS; r++)
                plan_command(CMD_WRITE, r, pattern_bits(density));
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Once in mid-phase the sender waits for every result.
                if (phase == 6 && n == PHASE_BEATS / 2)
                    plan_pause();
                pick = $urandom_range(99);
                if (pick < 20)
                    plan_command(CMD_WRITE, $urandom_range(15), pattern_bits(density));
                else if (pick < 45)
                    plan_command(CMD_STEP, $urandom_range(15), 16'($urandom));
                else if (pick < 94)
                    plan_command(CMD_READ, $urandom_range(15), 16'($urandom));
                else
                    plan_command(CMD_NOP, $urandom_range(15), 16'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Everything sent, everything answered, then a few quiet cycles
        // so that a stray extra result beat would still be caught.
        while (beat_plan.size() != 0 || cmd_busy || cfg_busy || settle_left != 0
               || row_data_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d writes, %0d steps, %0d reads and %0d no-ops over %0d register writes.",
                 beats_by_cmd[CMD_WRITE], beats_by_cmd[CMD_STEP], beats_by_cmd[CMD_READ],
                 beats_by_cmd[CMD_NOP], reg_writes);
        $display("Checked %0d result beats, %0d of them with live cells; %0d mismatches.",
                 results_checked, live_reads, failures);
        if (failures == 0 && row_data_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Driver. Inputs change on the falling edge only. A command beat stays
    // valid until it is taken; gaps are inserted only between beats. The
    // middle of the run goes without any random idling on either side.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_taken)
                cmd_busy = 1'b0;
            if (cfg_taken)
                cfg_busy = 1'b0;
            quiet = (beats_sent >= 500) && (beats_sent < 750);
            if (settle_left > 0)
                settle_left = settle_left - 1;
            else if (!cmd_busy && !cfg_busy && beat_plan.size() != 0)
            begin
                head = beat_plan[0];
                case (head.kind)
                    PLAN_PAUSE:
                        if (row_data_expected.size() == 0)
                        begin
                            beat_plan.delete(0);
                            settle_left = SETTLE_CYCLES;
                        end
                    PLAN_REG:
                    begin
                        beat_plan.delete(0);
                        cfg_busy = 1'b1;
                        cfg_index <= head.sel;
                        cfg_data  <= head.value;
                    end
                    default:
                        if (quiet || $urandom_range(99) >= IDLE_PCT)
                        begin
                            beat_plan.delete(0);
                            cmd_busy = 1'b1;
                            s_tdata <= {4'b0000, head.bits, head.row};
                            s_tuser <= head.op;
                            beats_sent++;
                        end
                endcase
            end
            s_tvalid  <= cmd_busy;
            cfg_valid <= cfg_busy;
            m_tready  <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor. Handshakes are sampled on the rising edge. A register write
    // or a command updates the mirror as it is taken, and each result beat
    // is compared with the oldest row data still owed.
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && s_tvalid && s_tready;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                set_area_register(cfg_reg_t'(cfg_index), cfg_data);
                reg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                row_data_expected.push_back(
                    apply_grid_command(cmd_t'(s_tuser), s_tdata[3:0], s_tdata[19:4]));
                beats_by_cmd[s_tuser]++;
            end
            if (m_tvalid && m_tready)
            begin
                if (row_data_expected.size() == 0)
                begin
                    $display("%0t: result beat row_data %h with no result outstanding",
                             $time, m_tdata);
                    failures++;
                end
                else
                begin
                    expected_row = row_data_expected.pop_front();
                    results_checked++;
                    if (m_tdata !== expected_row)
                    begin
                        $display("%0t: row_data mismatch, expected %h, got %h",
                                 $time, expected_row, m_tdata);
                        failures++;
                    end
                    else if (expected_row != 0)
                        live_reads++;
                end
            end
        end
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("%0t: timed out with %0d results outstanding",
                 $time, row_data_expected.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
